/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the decimal text formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SIDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/sida_pkg.sv */
// Package with the constants and types of the decimal text formatter.
`default_nettype none

package sida_pkg;

   // Default width of the signed input value.
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // One BCD digit per cell.
   localparam int DIGIT_WIDTH = 4;

   // ASCII codes that the formatter emits.
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Command that the controller broadcasts to every digit cell.
   typedef struct packed {
      logic clear;     // load zero into every digit
      logic dabble;    // add-3 correction and shift one binary bit in
      logic shift_up;  // move each digit one cell toward the top
   } sida_cell_ctrl_type;

endpackage

`default_nettype wire

/* hdl/sida_channels.sv */
// Interfaces of the request channel and the response channel.
`default_nettype none

// Request channel: one signed value per word.
interface sida_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

// Response channel: one ASCII byte per word.
interface sida_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       is_last;

   modport source (output valid, output character, output is_last, input ready);
   modport sink   (input valid, input character, input is_last, output ready);
endinterface

`default_nettype wire

/* hdl/sida_bcd_cell.sv */
// One BCD digit cell of the double-dabble chain.
`default_nettype none

module sida_bcd_cell (
   input  wire logic                                 clock,
   input  wire sida_pkg::sida_cell_ctrl_type         ctrl,
   input  wire logic                                 carry_in,
   input  wire logic [sida_pkg::DIGIT_WIDTH-1:0]     digit_below,
   output logic                                      carry_out,
   output logic [sida_pkg::DIGIT_WIDTH-1:0]          digit
);
   import sida_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [DIGIT_WIDTH-1:0] adjusted;

   // Add-3 correction: a digit of five or more overflows into the next cell on the shift.
   always_comb begin
      adjusted = (digit_ff >= DIGIT_WIDTH'(5)) ? (digit_ff + DIGIT_WIDTH'(3)) : digit_ff;
   end

   // Next digit according to the broadcast command.
   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.dabble) begin
         digit_in = {adjusted[DIGIT_WIDTH-2:0], carry_in};
      end else if (ctrl.shift_up) begin
         digit_in = digit_below;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adjusted[DIGIT_WIDTH-1];
   assign digit     = digit_ff;

endmodule

`default_nettype wire

/* hdl/signed_int_to_decimal_ascii.sv */
// Top level of the signed integer to decimal ASCII formatter.
// Each accepted request word carries one two's-complement value of VALUE_WIDTH bits; the
// block answers with its decimal text, one ASCII byte per response word: a leading '-' for
// a negative value, then the digits of the magnitude, most significant first, without
// leading zeros ("0" for zero), with is_last set on the final byte. The most negative value
// is printed exactly. The magnitude is converted by a chain of BCD digit cells that takes
// one binary bit per cycle, after which leading zero digits are shifted out of the
// top cell and the text leaves one byte per cycle while the response channel is ready.
// Requests are taken one at a time; the last byte may still wait in the output register
// while the next request is accepted.
`default_nettype none

`include "assert_macros.svh"

module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sida_req_if.sink   req_ch,
   sida_rsp_if.source rsp_ch
);
   import sida_pkg::*;

   // Digits needed for the largest magnitude, 2^(VALUE_WIDTH-1).
   localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
   localparam int REM_W      = $clog2(NUM_DIGITS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_SKIP  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [REM_W-1:0]       remaining_ff, remaining_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   sida_cell_ctrl_type     cell_ctrl;
   logic [DIGIT_WIDTH-1:0] digit [NUM_DIGITS];
   logic                   carry [NUM_DIGITS+1];
   logic [DIGIT_WIDTH-1:0] top_digit;
   logic                   out_free;

   // Chain of digit cells; the binary bits enter at the bottom cell.
   assign carry[0] = mag_ff[VALUE_WIDTH-1];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      logic [DIGIT_WIDTH-1:0] below;
      if (i == 0) begin : g_bottom
         assign below = '0;
      end else begin : g_upper
         assign below = digit[i-1];
      end
      sida_bcd_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .carry_in    (carry[i]),
         .digit_below (below),
         .carry_out   (carry[i+1]),
         .digit       (digit[i])
      );
   end

   assign top_digit = digit[NUM_DIGITS-1];
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Controller: load, convert, drop leading zeros, then emit sign and digits.
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      cell_ctrl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               neg_in          = req_ch.number[VALUE_WIDTH-1];
               mag_in          = req_ch.number[VALUE_WIDTH-1]
                               ? (~$unsigned(req_ch.number) + VALUE_WIDTH'(1))
                               : $unsigned(req_ch.number);
               count_in        = CNT_W'(VALUE_WIDTH);
               cell_ctrl.clear = 1'b1;
               state_in        = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cell_ctrl.dabble = 1'b1;
            mag_in           = mag_ff << 1;
            count_in         = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               remaining_in = REM_W'(NUM_DIGITS);
               state_in     = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && remaining_ff != REM_W'(1)) begin
               cell_ctrl.shift_up = 1'b1;
               remaining_in       = remaining_ff - REM_W'(1);
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_char_in        = CHAR_ZERO + {{(8-DIGIT_WIDTH){1'b0}}, top_digit};
               rsp_last_in        = (remaining_ff == REM_W'(1));
               cell_ctrl.shift_up = 1'b1;
               remaining_in       = remaining_ff - REM_W'(1);
               if (remaining_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      count_ff     <= count_in;
      remaining_ff <= remaining_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.character = rsp_char_ff;
   assign rsp_ch.is_last   = rsp_last_ff;

   // The magnitude always fits the chain, so nothing spills out of the top cell.
   `SIDA_ASSERT_NOW(a_no_top_overflow, clock, reset, cell_ctrl.dabble, !carry[NUM_DIGITS], "digit chain overflowed")
   // A minus sign is never the final byte of a number.
   `SIDA_ASSERT_NOW(a_sign_not_last, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_char_ff != CHAR_MINUS, "minus sign marked last")
   // While digits are being emitted at least one digit remains.
   `SIDA_ASSERT_NOW(a_emit_has_digit, clock, reset, state_ff == ST_EMIT, remaining_ff != '0, "emit with no digit left")
   // Leaving the leading-zero phase, the top digit is significant or it is the only digit.
   `SIDA_ASSERT_NEXT(a_skip_exit, clock, reset, state_ff == ST_SKIP && state_in != ST_SKIP, top_digit != '0 || remaining_ff == REM_W'(1), "leading zero left in text")

endmodule

`default_nettype wire

/* verif/signed_int_to_decimal_ascii_tb.sv */
// Testbench for the signed integer to decimal ASCII formatter.
`timescale 1ns / 1ps

// One expected byte of decimal text.
typedef struct packed {
   logic [7:0] character;
   logic       is_last;
} text_byte_type;

// Expected decimal text for every accepted number, checked byte by byte.
class decimal_text_scoreboard;
   localparam int unsigned DECIMAL_BASE = 10;

   text_byte_type expected_text[$];
   int            error_count = 0;

   // Format an accepted number and queue its bytes.
   function void note_number(logic [31:0] value);
      logic [31:0]   magnitude;
      logic [3:0]    digits[$];
      text_byte_type entry;
      // The unsigned negation gives 2^31 for the most negative value.
      magnitude = value[31] ? (~value + 32'd1) : value;
      do begin
         digits.push_front(4'(magnitude % DECIMAL_BASE));
         magnitude = magnitude / DECIMAL_BASE;
      end while (magnitude != 0);
      if (value[31]) begin
         entry.character = sida_pkg::CHAR_MINUS;
         entry.is_last   = 1'b0;
         expected_text.push_back(entry);
      end
      for (int i = 0; i < digits.size(); i++) begin
         entry.character = sida_pkg::CHAR_ZERO + 8'(digits[i]);
         entry.is_last   = (i == digits.size() - 1);
         expected_text.push_back(entry);
      end
   endfunction

   // Compare an accepted response word with the oldest expected byte.
   function void check_word(logic [7:0] character, logic is_last);
      text_byte_type want;
      if (expected_text.size() == 0) begin
         $error("unexpected word: character %0d, is_last %0b", character, is_last);
         error_count++;
         return;
      end
      want = expected_text.pop_front();
      if (want.character !== character) begin
         $error("character mismatch: expected %0d, actual %0d", want.character, character);
         error_count++;
      end
      if (want.is_last !== is_last) begin
         $error("is_last mismatch: expected %0b, actual %0b", want.is_last, is_last);
         error_count++;
      end
   endfunction

   function int pending();
      return expected_text.size();
   endfunction
endclass

module signed_int_to_decimal_ascii_tb;
   localparam int RANDOM_NUMBERS = 480;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;

   logic clock;
   logic reset;

   sida_req_if #(.VALUE_WIDTH(32)) req_ch ();
   sida_rsp_if                     rsp_ch ();

   signed_int_to_decimal_ascii #(.VALUE_WIDTH(32)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   decimal_text_scoreboard text_board;

   int sender_burst_left = 0;
   int stall_left        = 0;
   int calm_left         = 0;
   int stall_roll;
   int idle_cycles       = 0;
   bit progress;

   // Directed numbers: extremes, sign handling and the digit count boundaries at 10, 100 and 1000000000.
   logic [31:0] directed_numbers[20] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
      -32'sd999999999, 32'd1234567890, -32'sd1234567890, 32'h5555_5555,
      32'hAAAA_AAAA, 32'd7, -32'sd5
   };

   always #5 clock = ~clock;

   // Idle cycles before the next request word: mostly none, some short, a few long.
   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_burst_left > 0) begin
         sender_burst_left--;
         return 0;
      end
      if (roll < 3)
         sender_burst_left = $urandom_range(20, 80);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Random number: raw bit patterns, values of a chosen digit count, or
   // values at or next to a power of ten.
   function automatic logic [31:0] random_number();
      longint unsigned low_bound, span, magnitude;
      int              kind, digit_count;
      kind = $urandom_range(0, 9);
      if (kind < 4)
         return $urandom;
      digit_count = $urandom_range(1, 10);
      low_bound = 1;
      repeat (digit_count - 1) low_bound = low_bound * 10;
      if (kind == 9) begin
         magnitude = low_bound + $urandom_range(0, 2) - 1;
      end else begin
         span = low_bound * 10 - low_bound;
         if (digit_count == 1)
            low_bound = 0;
         if (low_bound + span > 64'd2147483648)
            span = 64'd2147483648 - low_bound + 1;
         magnitude = low_bound + ({$urandom, $urandom} % span);
      end
      if ($urandom_range(0, 1))
         return 32'(-magnitude);
      return 32'(magnitude);
   endfunction

   // Offer one number and return at the clock edge that accepts it.
   task automatic send_number(input logic [31:0] value);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.number <= value;
      do @(negedge clock); while (!req_ch.ready);
      text_board.note_number(value);
      @(posedge clock);
   endtask

   // Response side back-pressure, with calm stretches of steady ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (calm_left > 0) begin
         rsp_ch.ready <= 1'b1;
         calm_left = calm_left - 1;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_roll = $urandom_range(0, 999);
         if (stall_roll < 5)
            calm_left = $urandom_range(100, 400);
         else if (stall_roll < 30)
            stall_left = $urandom_range(10, 60);
         else if (stall_roll < 300)
            stall_left = $urandom_range(1, 3);
      end
   end

   // Handshakes are sampled at the falling edge, where both sides are stable;
   // a word seen there is taken at the next rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (req_ch.valid && req_ch.ready)
            progress = 1'b1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            text_board.check_word(rsp_ch.character, rsp_ch.is_last);
            progress = 1'b1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Reset, directed numbers, random numbers, then drain and report.
   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.number = '0;
      rsp_ch.ready  = 1'b0;
      text_board    = new;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_numbers[i])
         send_number(directed_numbers[i]);
      repeat (RANDOM_NUMBERS)
         send_number(random_number());
      req_ch.valid <= 1'b0;
      while (text_board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (text_board.error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/sida_pkg.sv
hdl/sida_channels.sv
hdl/sida_bcd_cell.sv
hdl/signed_int_to_decimal_ascii.sv
verif/signed_int_to_decimal_ascii_tb.sv
